// ===== sv/strt_pkg.sv =====
`default_nettype none
package strt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned QUERY_DEPTH_DEF = 32;

  // action codes
  localparam logic [1:0] ACT_ADMIT   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;
  localparam logic [1:0] ACT_QUERY   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_QUERY_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] action_id;
    logic [15:0] group_id;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [3:0]  cell_z;
    logic [15:0] first_step;
    logic [15:0] last_step;
    logic        open_end;
    logic [15:0] base_step;
    logic        last_in_set;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        done_res;
    logic        conflict_found;
    logic [15:0] held_by;
    logic [7:0]  conflict_x;
    logic [7:0]  conflict_y;
    logic [3:0]  conflict_z;
    logic [15:0] conflict_step;
  } rsp_t;

  typedef struct packed {
    logic [19:0] loc;
    logic [15:0] first;
    logic [15:0] last;
    logic        open;
  } span_t;

  typedef struct packed {
    span_t       span;
    logic [15:0] owner;
    logic [15:0] group;
    logic        start;
  } rec_t;

  // saturating 16-bit add
  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // query span a against record span b
  function automatic logic spans_meet(input span_t a, input span_t b);
    logic m;
    m = (a.loc == b.loc);
    if (!b.open && (a.first > b.last)) m = 1'b0;
    if (!a.open && (a.last < b.first)) m = 1'b0;
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== sv/strt_if.sv =====
`default_nettype none
interface strt_req_if;
  logic          valid;
  logic          ready;
  strt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface strt_rsp_if;
  logic          valid;
  logic          ready;
  strt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/strt_ram.sv =====
`default_nettype none
module strt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/space_time_reservation_table.sv =====
// admit, clear and a non-final query beat answer from a registered result in the cycle after accept
// release: each stored record is read (S_REL_RD) and, unless owned by the released id, kept (S_REL_WR)
// final query: per entry a head read and dispatch (S_HEAD, S_HEAD_W, S_ENT), an end scan (S_END, S_END_W),
//   then for a non-exempt entry a compare (S_CMP) of each (query span, entry record) pair, until the first conflict
// one item at a time; reset (synchronous, active high) empties table and query set
`default_nettype none
module space_time_reservation_table #(
  parameter int unsigned TABLE_DEPTH = strt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned QUERY_DEPTH = strt_pkg::QUERY_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  strt_req_if.sink   req,
  strt_rsp_if.source rsp
);
  localparam int unsigned TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TCW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned QAW = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUERY_DEPTH + 1);
  localparam logic [TCW-1:0] T_ONE  = TCW'(1);
  localparam logic [TCW-1:0] T_FULL = TCW'(TABLE_DEPTH);
  localparam logic [QCW-1:0] Q_ONE  = QCW'(1);
  localparam logic [QCW-1:0] Q_FULL = QCW'(QUERY_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_REL_RD = 9'b000000010,
    S_REL_WR = 9'b000000100,
    S_HEAD   = 9'b000001000,
    S_HEAD_W = 9'b000010000,
    S_END    = 9'b000100000,
    S_END_W  = 9'b001000000,
    S_ENT    = 9'b010000000,
    S_CMP    = 9'b100000000
  } state_t;

  state_t          state;
  logic [TCW-1:0]  count;
  logic [QCW-1:0]  qcount;
  logic            entry_open;
  logic [15:0]     cur_owner;
  logic [15:0]     cur_group;
  logic [15:0]     rel_id;
  logic [15:0]     exempt;
  logic [1:0]      q_status;
  logic [TCW-1:0]  ri;
  logic [TCW-1:0]  wk;
  logic [TCW-1:0]  s;
  logic [TCW-1:0]  e;
  logic [TCW-1:0]  j;
  logic [QCW-1:0]  qi;
  logic [15:0]     ent_owner;
  logic            skip;
  logic            cmp_w;
  logic            out_valid;
  strt_pkg::rsp_t  out_data;

  logic            accept;
  strt_pkg::span_t new_span;
  strt_pkg::rec_t  new_rec;
  strt_pkg::rec_t  rec_wdata;
  strt_pkg::rec_t  rec_rdata;
  strt_pkg::span_t q_rdata;
  logic            rec_we;
  logic [TAW-1:0]  rec_waddr;
  logic [TAW-1:0]  rec_raddr;
  logic            q_we;
  logic            meet;
  strt_pkg::rsp_t  idle_rsp;
  strt_pkg::rsp_t  fin_rsp;
  strt_pkg::rsp_t  hit_rsp;

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // offset span of the incoming beat
  always_comb begin
    new_span.loc   = {req.data.cell_z, req.data.cell_y, req.data.cell_x};
    new_span.first = strt_pkg::sat_add(req.data.first_step, req.data.base_step);
    new_span.open  = req.data.open_end;
    new_span.last  = req.data.open_end ? 16'd0
                   : strt_pkg::sat_add(req.data.last_step, req.data.base_step);
    new_rec.span   = new_span;
    if (entry_open && (count != '0)) begin
      new_rec.owner = cur_owner;
      new_rec.group = cur_group;
      new_rec.start = 1'b0;
    end else begin
      new_rec.owner = req.data.action_id;
      new_rec.group = req.data.group_id;
      new_rec.start = 1'b1;
    end
  end

  // result of a beat answered from idle, formed in its accept cycle
  always_comb begin
    idle_rsp = '0;
    if ((req.data.action == strt_pkg::ACT_ADMIT) && (count == T_FULL)) begin
      idle_rsp.status = strt_pkg::ST_TABLE_FULL;
    end
    if (req.data.action == strt_pkg::ACT_QUERY) begin
      if (qcount == Q_FULL) begin
        idle_rsp.status = strt_pkg::ST_QUERY_FULL;
      end
      idle_rsp.done_res = req.data.last_in_set;
    end
  end

  // results at the end of a final query walk
  always_comb begin
    fin_rsp                = '0;
    fin_rsp.status         = q_status;
    fin_rsp.done_res       = 1'b1;
    hit_rsp                = fin_rsp;
    hit_rsp.conflict_found = 1'b1;
    hit_rsp.held_by        = ent_owner;
    hit_rsp.conflict_x     = q_rdata.loc[7:0];
    hit_rsp.conflict_y     = q_rdata.loc[15:8];
    hit_rsp.conflict_z     = q_rdata.loc[19:16];
    hit_rsp.conflict_step  = (q_rdata.first > rec_rdata.span.first)
                             ? q_rdata.first : rec_rdata.span.first;
  end

  // record ram port control
  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = count[TAW-1:0];
    rec_wdata = new_rec;
    rec_raddr = ri[TAW-1:0];
    if (accept && (req.data.action == strt_pkg::ACT_ADMIT) && (count != T_FULL)) begin
      rec_we = 1'b1;
    end
    if ((state == S_REL_WR) && (rec_rdata.owner != rel_id)) begin
      rec_we    = 1'b1;
      rec_waddr = wk[TAW-1:0];
      rec_wdata = rec_rdata;
    end
    case (state)
      S_HEAD:  rec_raddr = s[TAW-1:0];
      S_END:   rec_raddr = e[TAW-1:0];
      S_CMP:   rec_raddr = j[TAW-1:0];
      default: rec_raddr = ri[TAW-1:0];
    endcase
  end

  assign q_we = accept && (req.data.action == strt_pkg::ACT_QUERY) && (qcount != Q_FULL);
  assign meet = strt_pkg::spans_meet(q_rdata, rec_rdata.span);

  strt_ram #(.WIDTH($bits(strt_pkg::rec_t)), .DEPTH(TABLE_DEPTH)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  strt_ram #(.WIDTH($bits(strt_pkg::span_t)), .DEPTH(QUERY_DEPTH)) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (qcount[QAW-1:0]),
    .wdata (new_span),
    .raddr (qi[QAW-1:0]),
    .rdata (q_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      qcount     <= '0;
      entry_open <= 1'b0;
      out_valid  <= 1'b0;
      cmp_w      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            out_data <= idle_rsp;
            case (req.data.action)
              strt_pkg::ACT_ADMIT: begin
                out_valid  <= 1'b1;
                entry_open <= !req.data.last_in_set;
                if (count != T_FULL) begin
                  count     <= count + T_ONE;
                  cur_owner <= new_rec.owner;
                  cur_group <= new_rec.group;
                end
              end
              strt_pkg::ACT_RELEASE: begin
                entry_open <= 1'b0;
                rel_id     <= req.data.action_id;
                ri         <= '0;
                wk         <= '0;
                out_valid  <= (count == '0);
                if (count != '0) begin
                  state <= S_REL_RD;
                end
              end
              strt_pkg::ACT_CLEAR: begin
                out_valid  <= 1'b1;
                count      <= '0;
                entry_open <= 1'b0;
              end
              default: begin
                q_status  <= idle_rsp.status;
                exempt    <= req.data.group_id;
                s         <= '0;
                out_valid <= !req.data.last_in_set || (count == '0);
                if (req.data.last_in_set && (count == '0)) begin
                  qcount <= '0;
                end else if (qcount != Q_FULL) begin
                  qcount <= qcount + Q_ONE;
                end
                if (req.data.last_in_set && (count != '0)) begin
                  state <= S_HEAD;
                end
              end
            endcase
          end else if (out_valid && rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        S_REL_RD: begin
          state <= S_REL_WR;
        end
        S_REL_WR: begin
          if (rec_we) begin
            wk <= wk + T_ONE;
          end
          ri <= ri + T_ONE;
          if (ri + T_ONE == count) begin
            count     <= rec_we ? wk + T_ONE : wk;
            out_valid <= 1'b1;
            out_data  <= '0;
            state     <= S_IDLE;
          end else begin
            state <= S_REL_RD;
          end
        end
        S_HEAD: begin
          state <= S_HEAD_W;
        end
        S_HEAD_W: begin
          ent_owner <= rec_rdata.owner;
          skip      <= ((exempt != 16'd0) && (rec_rdata.group == exempt)) || (qcount == '0);
          e         <= s + T_ONE;
          state     <= (s + T_ONE == count) ? S_ENT : S_END;
        end
        S_END: begin
          state <= S_END_W;
        end
        S_END_W: begin
          if (rec_rdata.start) begin
            state <= S_ENT;
          end else begin
            e     <= e + T_ONE;
            state <= (e + T_ONE == count) ? S_ENT : S_END;
          end
        end
        S_ENT: begin
          qi    <= '0;
          j     <= s;
          cmp_w <= 1'b0;
          if (!skip) begin
            state <= S_CMP;
          end else if (e == count) begin
            out_valid <= 1'b1;
            out_data  <= fin_rsp;
            qcount    <= '0;
            state     <= S_IDLE;
          end else begin
            s     <= e;
            state <= S_HEAD;
          end
        end
        S_CMP: begin
          // with cmp_w low the reads are issued, with cmp_w high the pair is evaluated
          cmp_w <= !cmp_w;
          if (cmp_w) begin
            if (meet) begin
              out_valid <= 1'b1;
              out_data  <= hit_rsp;
              qcount    <= '0;
              state     <= S_IDLE;
            end else if (j + T_ONE != e) begin
              j <= j + T_ONE;
            end else if (qi + Q_ONE != qcount) begin
              j  <= s;
              qi <= qi + Q_ONE;
            end else if (e == count) begin
              out_valid <= 1'b1;
              out_data  <= fin_rsp;
              qcount    <= '0;
              state     <= S_IDLE;
            end else begin
              s     <= e;
              state <= S_HEAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/strt_checker.sv =====
`default_nettype none
module strt_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire strt_pkg::rsp_t  out_data
);
  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // no new item while a result waits
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("ready while result pending");

  // reset leaves no result
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status");

  // conflict only on a final query beat
  a_conflict_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.conflict_found |-> out_data.done_res)
    else $error("conflict without done");
endmodule

bind space_time_reservation_table strt_checker u_strt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_data  (rsp.data)
);
`default_nettype wire
